// File: rtl/mppt_sweep_tracker_unit_macros.svh
// ----------------------------------------------------------------------------
// MPPT sweep tracker assertion macros
// Shared concurrent assertion forms, clocked on clk and idle during reset.
// ----------------------------------------------------------------------------
`ifndef MPPT_SWEEP_TRACKER_UNIT_MACROS_SVH
`define MPPT_SWEEP_TRACKER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MST_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MST_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/mst_pkg.sv
// ----------------------------------------------------------------------------
// MPPT sweep tracker package
// Transaction types, derived configuration terms and shared constants.
// ----------------------------------------------------------------------------
package mst_pkg;

  // Input transaction: start with open-circuit code, or a current reading.
  typedef struct packed {
    logic       action;
    logic [7:0] reading;
    logic       power_good;
  } mst_in_t;

  // Result transaction.
  typedef struct packed {
    logic [7:0] limit_code;
    logic       final_res;
  } mst_out_t;

  // Precomputed bound terms handed from the configuration block to the core.
  typedef struct packed {
    logic [21:0] pk_lo;
    logic [21:0] pk_hi;
    logic [7:0]  bterm_lo;
    logic [7:0]  bterm_hi;
    logic        busy;
  } mst_terms_t;

  // Action codes.
  localparam logic ACT_START   = 1'b0;
  localparam logic ACT_READING = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] CFG_IDX_LOW_PCT  = 2'd0;
  localparam logic [1:0] CFG_IDX_HIGH_PCT = 2'd1;
  localparam logic [1:0] CFG_IDX_OFFSET   = 2'd2;

  // Configuration reset values.
  localparam logic [6:0] LOW_PCT_RST  = 7'd70;
  localparam logic [6:0] HIGH_PCT_RST = 7'd90;
  localparam logic [6:0] OFFSET_RST   = 7'd26;

  // Division by 100 as multiply by ceil(2^21/100) and shift; exact below 43690.
  localparam logic [14:0] RECIP_K     = 15'd20972;
  localparam int          RECIP_SHIFT = 21;
  localparam logic [6:0]  PCT_SCALE   = 7'd100;

  localparam logic [7:0] CLAMP_LOW_CODE = 8'h0D;
  localparam logic [7:0] PLATEAU_MAX    = 8'hFF;

  // Cycles for the derived terms to settle after reset or a register write.
  localparam logic [1:0] REFRESH_CYCLES = 2'd2;

endpackage

// File: rtl/mst_bound.sv
// ----------------------------------------------------------------------------
// MPPT sweep bound unit
// Computes pct*voc/100 minus the precomputed offset term, modulo 256.
// ----------------------------------------------------------------------------
module mst_bound (
  input  logic [21:0] pk,
  input  logic [7:0]  bterm,
  input  logic [7:0]  voc,
  output logic [7:0]  bound
);
  import mst_pkg::*;

  logic [29:0] prod;

  // pk already holds pct*ceil(2^21/100), so one multiply gives the quotient.
  assign prod  = 30'(pk) * 30'(voc);
  assign bound = prod[RECIP_SHIFT +: 8] - bterm;

endmodule

// File: rtl/mst_cfg.sv
// ----------------------------------------------------------------------------
// MPPT sweep configuration block
// Holds the percent and offset registers and precomputes the bound terms.
// ----------------------------------------------------------------------------
module mst_cfg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [6:0]          cfg_data,
  output mst_pkg::mst_terms_t terms
);
  import mst_pkg::*;

  logic [6:0]  low_pct_r;
  logic [6:0]  high_pct_r;
  logic [6:0]  offset_r;
  logic [1:0]  rfsh_cnt_r;
  logic [1:0]  rfsh_cnt_nxt;
  logic        cfg_fire;

  logic [21:0] pk_lo_r;
  logic [21:0] pk_hi_r;
  logic [13:0] prod_lo_r;
  logic [13:0] prod_hi_r;
  logic        neg_lo_r;
  logic        neg_hi_r;
  logic [7:0]  bterm_lo_r;
  logic [7:0]  bterm_hi_r;
  logic [28:0] quo_lo;
  logic [28:0] quo_hi;

  // Distance of a percent from 100, as a magnitude.
  function automatic logic [6:0] pct_gap(input logic [6:0] p);
    if (p > PCT_SCALE) begin
      return p - PCT_SCALE;
    end else begin
      return PCT_SCALE - p;
    end
  endfunction

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  // Register writes; an index past the list is accepted and dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_pct_r  <= LOW_PCT_RST;
      high_pct_r <= HIGH_PCT_RST;
      offset_r   <= OFFSET_RST;
      rfsh_cnt_r <= REFRESH_CYCLES;
    end else begin
      if (cfg_fire) begin
        unique case (cfg_index)
          CFG_IDX_LOW_PCT:  low_pct_r  <= cfg_data;
          CFG_IDX_HIGH_PCT: high_pct_r <= cfg_data;
          CFG_IDX_OFFSET:   offset_r   <= cfg_data;
          default: ;
        endcase
      end
      rfsh_cnt_r <= rfsh_cnt_nxt;
    end
  end

  // Refresh counter keeps the input closed until the derived terms settle.
  always_comb begin
    if (cfg_fire) begin
      rfsh_cnt_nxt = REFRESH_CYCLES;
    end else if (rfsh_cnt_r != 2'd0) begin
      rfsh_cnt_nxt = rfsh_cnt_r - 2'd1;
    end else begin
      rfsh_cnt_nxt = rfsh_cnt_r;
    end
  end

  // Second stage: divide the offset products by 100 through the reciprocal.
  assign quo_lo = 29'(prod_lo_r) * 29'(RECIP_K);
  assign quo_hi = 29'(prod_hi_r) * 29'(RECIP_K);

  // Free-running two-stage pipeline for the derived terms.
  always_ff @(posedge clk) begin
    pk_lo_r    <= 22'(low_pct_r) * 22'(RECIP_K);
    pk_hi_r    <= 22'(high_pct_r) * 22'(RECIP_K);
    prod_lo_r  <= 14'(pct_gap(low_pct_r)) * 14'(offset_r);
    prod_hi_r  <= 14'(pct_gap(high_pct_r)) * 14'(offset_r);
    neg_lo_r   <= (low_pct_r > PCT_SCALE);
    neg_hi_r   <= (high_pct_r > PCT_SCALE);
    // A percent above 100 makes the term negative; the quotient is truncated first.
    bterm_lo_r <= neg_lo_r ? 8'(-{1'b0, quo_lo[RECIP_SHIFT +: 7]})
                           : {1'b0, quo_lo[RECIP_SHIFT +: 7]};
    bterm_hi_r <= neg_hi_r ? 8'(-{1'b0, quo_hi[RECIP_SHIFT +: 7]})
                           : {1'b0, quo_hi[RECIP_SHIFT +: 7]};
  end

  assign terms.pk_lo    = pk_lo_r;
  assign terms.pk_hi    = pk_hi_r;
  assign terms.bterm_lo = bterm_lo_r;
  assign terms.bterm_hi = bterm_hi_r;
  assign terms.busy     = cfg_valid || (rfsh_cnt_r != 2'd0);

endmodule

// File: rtl/mst_core.sv
// ----------------------------------------------------------------------------
// MPPT sweep tracker core
// Input register, sweep state update and result register.
// ----------------------------------------------------------------------------
`include "mppt_sweep_tracker_unit_macros.svh"

module mst_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mst_pkg::mst_in_t    in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mst_pkg::mst_out_t   out_data,
  input  mst_pkg::mst_terms_t terms
);
  import mst_pkg::*;

  // Input stage.
  logic       s_valid_r;
  logic       s_valid_nxt;
  mst_in_t    s_item_r;
  logic       s_emit;
  logic       s_fire;
  logic       in_fire;

  // Output stage.
  logic       out_valid_r;
  logic       out_valid_nxt;
  mst_out_t   out_data_r;
  mst_out_t   res_nxt;
  logic       out_space;
  logic       emit;

  // Sweep state.
  logic       sweeping_r;
  logic       sweeping_nxt;
  logic [7:0] probe_code_r;
  logic [7:0] probe_code_nxt;
  logic [7:0] upper_bound_r;
  logic [7:0] upper_bound_nxt;
  logic [7:0] best_current_r;
  logic [7:0] best_current_nxt;
  logic [7:0] best_code_r;
  logic [7:0] best_code_nxt;
  logic [7:0] plateau_r;
  logic [7:0] plateau_nxt;

  // Per-item values.
  logic [7:0] bound_lo;
  logic [7:0] bound_hi;
  logic [7:0] lo_code;
  logic [7:0] upd_current;
  logic [7:0] upd_code;
  logic [7:0] upd_plateau;
  logic [7:0] probe_inc;

  mst_bound u_bound_lo (
    .pk    (terms.pk_lo),
    .bterm (terms.bterm_lo),
    .voc   (s_item_r.reading),
    .bound (bound_lo)
  );

  mst_bound u_bound_hi (
    .pk    (terms.pk_hi),
    .bterm (terms.bterm_hi),
    .voc   (s_item_r.reading),
    .bound (bound_hi)
  );

  // Handshake: a reading while sweeping and a good start always produce a result.
  assign s_emit    = (s_item_r.action == ACT_READING) ? sweeping_r : s_item_r.power_good;
  assign out_space = !out_valid_r || out_ready;
  assign s_fire    = s_valid_r && (!s_emit || out_space);
  assign emit      = s_fire && s_emit;
  assign in_ready  = !terms.busy && (!s_valid_r || s_fire);
  assign in_fire   = in_valid && in_ready;

  // Lower bound is raised to the minimum usable code.
  assign lo_code   = (bound_lo < CLAMP_LOW_CODE) ? CLAMP_LOW_CODE : bound_lo;
  assign probe_inc = probe_code_r + 8'd1;

  // Best-current tracking for a reading that is not a drop.
  always_comb begin
    upd_current = best_current_r;
    upd_code    = best_code_r;
    upd_plateau = plateau_r;
    if (s_item_r.reading > best_current_r) begin
      upd_current = s_item_r.reading;
      upd_code    = probe_code_r;
      upd_plateau = 8'd0;
    end else if (probe_code_r > best_code_r) begin
      upd_code    = probe_code_r;
      upd_plateau = (plateau_r == PLATEAU_MAX) ? plateau_r : plateau_r + 8'd1;
    end
  end

  // Sweep state update and result selection.
  always_comb begin
    sweeping_nxt     = sweeping_r;
    probe_code_nxt   = probe_code_r;
    upper_bound_nxt  = upper_bound_r;
    best_current_nxt = best_current_r;
    best_code_nxt    = best_code_r;
    plateau_nxt      = plateau_r;
    res_nxt          = '0;
    if (s_fire) begin
      if (s_item_r.action == ACT_START) begin
        if (s_item_r.power_good) begin
          upper_bound_nxt  = bound_hi;
          probe_code_nxt   = lo_code;
          best_current_nxt = 8'd0;
          best_code_nxt    = 8'd0;
          plateau_nxt      = 8'd0;
          if (lo_code < bound_hi) begin
            sweeping_nxt = 1'b1;
            res_nxt      = '{limit_code: lo_code, final_res: 1'b0};
          end else begin
            // Empty window: the final code of a fresh search is zero.
            sweeping_nxt = 1'b0;
            res_nxt      = '{limit_code: 8'd0, final_res: 1'b1};
          end
        end
      end else if (sweeping_r) begin
        if (s_item_r.reading < best_current_r) begin
          // Current dropped: settle on the best code seen so far, less half the plateau.
          sweeping_nxt = 1'b0;
          res_nxt      = '{limit_code: best_code_r - {1'b0, plateau_r[7:1]},
                           final_res: 1'b1};
        end else begin
          best_current_nxt = upd_current;
          best_code_nxt    = upd_code;
          plateau_nxt      = upd_plateau;
          probe_code_nxt   = probe_inc;
          if (probe_inc < upper_bound_r) begin
            res_nxt = '{limit_code: probe_inc, final_res: 1'b0};
          end else begin
            sweeping_nxt = 1'b0;
            res_nxt      = '{limit_code: upd_code - {1'b0, upd_plateau[7:1]},
                             final_res: 1'b1};
          end
        end
      end
    end
  end

  // Stage valid flags.
  always_comb begin
    if (in_fire) begin
      s_valid_nxt = 1'b1;
    end else if (s_fire) begin
      s_valid_nxt = 1'b0;
    end else begin
      s_valid_nxt = s_valid_r;
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control and state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r      <= 1'b0;
      out_valid_r    <= 1'b0;
      sweeping_r     <= 1'b0;
      probe_code_r   <= 8'd0;
      upper_bound_r  <= 8'd0;
      best_current_r <= 8'd0;
      best_code_r    <= 8'd0;
      plateau_r      <= 8'd0;
    end else begin
      s_valid_r      <= s_valid_nxt;
      out_valid_r    <= out_valid_nxt;
      sweeping_r     <= sweeping_nxt;
      probe_code_r   <= probe_code_nxt;
      upper_bound_r  <= upper_bound_nxt;
      best_current_r <= best_current_nxt;
      best_code_r    <= best_code_nxt;
      plateau_r      <= plateau_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s_item_r <= in_data;
    end
    if (emit) begin
      out_data_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A final result always leaves the tracker idle.
  `MST_ASSERT_NEXT(a_final_goes_idle, emit && res_nxt.final_res, !sweeping_r, "final result left sweep active")
  // While sweeping, the probe stays strictly below the upper edge of the window.
  `MST_ASSERT_NOW(a_probe_in_window, sweeping_r, probe_code_r < upper_bound_r, "probe outside sweep window")
  // A non-final result from a reading advances the probe by exactly one code.
  `MST_ASSERT_NEXT(a_probe_steps, emit && !res_nxt.final_res && (s_item_r.action == ACT_READING), probe_code_r == $past(probe_code_r) + 8'd1, "probe did not step by one")

endmodule

// File: rtl/mppt_sweep_tracker_unit.sv
// Each transaction waits in the input register; its result, if any, is then registered.
// Throughput: one input transaction per cycle, unless a held result or a refresh stalls it.
// The sweep state update is one compare-and-select pass after the input register.
// Reset (synchronous, rst_n low) clears the sweep state and loads the default registers.
// After reset or a register write the input stays closed while the refresh counter runs and the
// precomputed offset terms (two pipelined constant divisions) settle.
// ----------------------------------------------------------------------------
// MPPT sweep tracker top level
// Voltage-sweep maximum power point search with configurable sweep window.
// ----------------------------------------------------------------------------
module mppt_sweep_tracker_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  mst_pkg::mst_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output mst_pkg::mst_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [6:0]        cfg_data
);
  import mst_pkg::*;

  mst_terms_t terms;

  // Configuration registers and derived bound terms.
  mst_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .terms     (terms)
  );

  // Sweep tracking datapath.
  mst_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .terms     (terms)
  );

endmodule

// File: tb/sv/tb_mppt_sweep_tracker_unit.sv
// ----------------------------------------------------------------------------
// MPPT sweep tracker testbench
// Drives start and current-reading transactions into the sweep tracker,
// predicts every limit code and final operating point in a local tracker
// model, and checks each result transaction in order under random stalls.
// ----------------------------------------------------------------------------
module tb_mppt_sweep_tracker_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import mst_pkg::*;

  localparam int PERCENT_DIV    = 100;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int RANDOM_RESULTS = 950;
  localparam int STEADY_RESULTS = 150;
  localparam int IDLE_PCT       = 22;
  localparam int SETTLE_CYCLES  = 4;
  localparam int RESET_CYCLES   = 9;

  // Block ports; the inputs are known from time zero.
  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  mst_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  mst_out_t out_data;
  logic     cfg_valid = 1'b0;
  logic     cfg_ready;
  logic [1:0] cfg_index = CFG_IDX_LOW_PCT;
  logic [6:0] cfg_data  = '0;

  // Tracker model state and its copy of the registers.
  logic [6:0] low_pct  = LOW_PCT_RST;
  logic [6:0] high_pct = HIGH_PCT_RST;
  logic [6:0] off_reg  = OFFSET_RST;
  bit         sw_active    = 1'b0;
  logic [7:0] sw_probe     = '0;
  logic [7:0] sw_upper     = '0;
  logic [7:0] sw_best_cur  = '0;
  logic [7:0] sw_best_code = '0;
  logic [7:0] sw_plateau   = '0;

  mst_out_t pending_codes[$];
  int       results_sent   = 0;
  int       mismatch_count = 0;
  int       cycle_count    = 0;
  bit       steady_flow    = 1'b0;

  mppt_sweep_tracker_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Sweep window edge: percent of the open-circuit code minus the scaled offset.
  function automatic logic [7:0] window_bound(input logic [6:0] pct, input logic [7:0] voc);
    int p;
    int a;
    int b;
    p = int'(pct);
    a = (p * int'(voc)) / PERCENT_DIV;
    b = ((PERCENT_DIV - p) * int'(off_reg)) / PERCENT_DIV;
    return 8'(a - b);
  endfunction

  // Advance the tracker model by one transaction and form its result, if any.
  function automatic void track_sweep(input mst_in_t item, output bit produced,
                                      output mst_out_t res);
    logic [7:0] lo;
    bit         done;
    produced = 1'b0;
    res      = '0;
    done     = 1'b0;
    if (item.action == ACT_START) begin
      // A start without power good leaves everything untouched.
      if (!item.power_good) return;
      lo = window_bound(low_pct, item.reading);
      if (lo < CLAMP_LOW_CODE) lo = CLAMP_LOW_CODE;
      sw_upper     = window_bound(high_pct, item.reading);
      sw_probe     = lo;
      sw_best_cur  = '0;
      sw_best_code = '0;
      sw_plateau   = '0;
      done = !(sw_probe < sw_upper);
    end else begin
      if (!sw_active) return;
      if (item.reading > sw_best_cur) begin
        sw_plateau   = '0;
        sw_best_cur  = item.reading;
        sw_best_code = sw_probe;
      end else if (item.reading == sw_best_cur) begin
        if (sw_probe > sw_best_code) begin
          sw_best_code = sw_probe;
          if (sw_plateau < PLATEAU_MAX) sw_plateau = sw_plateau + 8'd1;
        end
      end else begin
        done = 1'b1;
      end
      if (!done) begin
        sw_probe = sw_probe + 8'd1;
        done = !(sw_probe < sw_upper);
      end
    end
    produced = 1'b1;
    if (done) begin
      sw_active      = 1'b0;
      res.limit_code = sw_best_code - (sw_plateau >> 1);
      res.final_res  = 1'b1;
    end else begin
      sw_active      = 1'b1;
      res.limit_code = sw_probe;
      res.final_res  = 1'b0;
    end
  endfunction

  // Result side stalls at random unless the steady stretch is running.
  always @(negedge clk) begin
    out_ready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
  end

  // Compare each result transaction with the oldest predicted code.
  always @(posedge clk) begin : result_check
    mst_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_codes.size() == 0) begin
        $error("unexpected result: limit_code %0d final_res %0d",
               out_data.limit_code, out_data.final_res);
        mismatch_count++;
      end else begin
        want = pending_codes.pop_front();
        if (out_data.limit_code !== want.limit_code) begin
          $error("limit_code: expected %0d, actual %0d", want.limit_code, out_data.limit_code);
          mismatch_count++;
        end
        if (out_data.final_res !== want.final_res) begin
          $error("final_res: expected %0d, actual %0d", want.final_res, out_data.final_res);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Send one input transaction after an optional random gap.
  task automatic send_item(input logic act, input logic [7:0] rd, input logic pg);
    mst_in_t  item;
    mst_out_t res;
    bit       produced;
    item.action     = act;
    item.reading    = rd;
    item.power_good = pg;
    @(negedge clk);
    while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    track_sweep(item, produced, res);
    if (produced) begin
      pending_codes.push_back(res);
      results_sent++;
    end
  endtask

  // Stop sending and wait until every predicted result has come back.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_codes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write transaction; only called while the block is idle.
  task automatic write_reg(input logic [1:0] idx, input logic [6:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_IDX_LOW_PCT:  low_pct  = val;
      CFG_IDX_HIGH_PCT: high_pct = val;
      CFG_IDX_OFFSET:   off_reg  = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_window(input logic [6:0] lo, input logic [6:0] hi, input logic [6:0] off);
    write_reg(CFG_IDX_LOW_PCT, lo);
    write_reg(CFG_IDX_HIGH_PCT, hi);
    write_reg(CFG_IDX_OFFSET, off);
  endtask

  // One sweep with a rising, flat and falling current profile, or a burst of noise.
  task automatic run_random_sweep();
    int         roll;
    int         steps;
    int         drop_pct;
    logic [7:0] rd;
    roll = $urandom_range(99);
    if (roll < 8) begin
      repeat ($urandom_range(1, 4))
        send_item(1'($urandom_range(1)), 8'($urandom_range(255)), 1'($urandom_range(1)));
      return;
    end
    send_item(ACT_START, 8'($urandom_range(255)), 1'b1);
    drop_pct = $urandom_range(1, 20);
    steps = 0;
    while (sw_active && steps < 300) begin
      roll = $urandom_range(99);
      steps++;
      if (roll < 2) begin
        // Start without power good in the middle of a sweep.
        send_item(ACT_START, 8'($urandom_range(255)), 1'b0);
      end else if (roll < 4) begin
        // Restart with a fresh open-circuit code.
        send_item(ACT_START, 8'($urandom_range(255)), 1'b1);
      end else if (roll < 4 + drop_pct && sw_best_cur != 8'd0) begin
        rd = 8'($urandom_range(int'(sw_best_cur) - 1));
        send_item(ACT_READING, rd, 1'($urandom_range(1)));
      end else if (roll < 60 && sw_best_cur != 8'hFF) begin
        rd = 8'($urandom_range(int'(sw_best_cur) + 1,
                                (int'(sw_best_cur) + 24 > 255) ? 255 : int'(sw_best_cur) + 24));
        send_item(ACT_READING, rd, 1'($urandom_range(1)));
      end else begin
        send_item(ACT_READING, sw_best_cur, 1'($urandom_range(1)));
      end
    end
    // Occasionally a stray reading arrives after the sweep has ended.
    if (!sw_active && $urandom_range(99) < 10)
      send_item(ACT_READING, 8'($urandom_range(255)), 1'($urandom_range(1)));
  endtask

  // Picks a typical window most of the time and any register value otherwise.
  task automatic pick_window();
    logic [6:0] lo;
    logic [6:0] hi;
    if ($urandom_range(99) < 75) begin
      lo = 7'($urandom_range(30, 85));
      hi = 7'($urandom_range(int'(lo), 100));
      write_window(lo, hi, 7'($urandom_range(0, 60)));
    end else begin
      write_window(7'($urandom_range(127)), 7'($urandom_range(127)), 7'($urandom_range(127)));
    end
  endtask

  // Reset register values: the named corner cases in a short sequence.
  task automatic test_directed();
    send_item(ACT_START, 8'hFF, 1'b0);
    send_item(ACT_READING, 8'hAA, 1'b1);
    send_item(ACT_START, 8'd30, 1'b1);
    send_item(ACT_READING, 8'd0, 1'b0);
    send_item(ACT_READING, 8'd40, 1'b1);
    send_item(ACT_READING, 8'd40, 1'b1);
    send_item(ACT_READING, 8'd40, 1'b0);
    send_item(ACT_START, 8'd0, 1'b0);
    send_item(ACT_READING, 8'hFF, 1'b1);
    send_item(ACT_READING, 8'hFF, 1'b1);
    send_item(ACT_READING, 8'hFE, 1'b1);
    send_item(ACT_START, 8'hFF, 1'b1);
    send_item(ACT_READING, 8'd1, 1'b1);
    // Restart mid-sweep, then ride the window up to its upper edge.
    send_item(ACT_START, 8'd30, 1'b1);
    for (int i = 1; i <= 11; i++) send_item(ACT_READING, 8'(i * 20), 1'b1);
  endtask

  // Register extremes, including empty windows and the widest window.
  task automatic test_register_extremes();
    write_window(7'd100, 7'd0, 7'd0);
    send_item(ACT_START, 8'h80, 1'b1);
    drain_results();
    write_window(7'd0, 7'd127, 7'd127);
    send_item(ACT_START, 8'h00, 1'b1);
    send_item(ACT_START, 8'hFF, 1'b1);
    send_item(ACT_READING, 8'd5, 1'b1);
    drain_results();
    write_window(7'd127, 7'd127, 7'd0);
    send_item(ACT_START, 8'h55, 1'b1);
    drain_results();
    write_window(7'd0, 7'd100, 7'd0);
    send_item(ACT_START, 8'hFF, 1'b1);
    send_item(ACT_READING, 8'd10, 1'b1);
    send_item(ACT_READING, 8'd10, 1'b1);
    send_item(ACT_READING, 8'd9, 1'b1);
  endtask

  // Random sweeps over a series of register settings.
  task automatic test_random_sweeps(input int goal);
    while (results_sent < goal) begin
      drain_results();
      pick_window();
      for (int s = 0; s < 25 && results_sent < goal; s++) run_random_sweep();
    end
  endtask

  // A long stretch with neither side idling.
  task automatic test_steady_stream(input int goal);
    drain_results();
    write_window(7'd60, 7'd95, 7'd20);
    steady_flow = 1'b1;
    while (results_sent < goal) run_random_sweep();
    steady_flow = 1'b0;
  endtask

  initial begin
    int base;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    drain_results();
    test_register_extremes();
    base = results_sent;
    test_random_sweeps(base + RANDOM_RESULTS - STEADY_RESULTS);
    test_steady_stream(base + RANDOM_RESULTS);
    drain_results();
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
